// ----- rtl/contiguous_block_allocator_unit_assert.svh -----
// Assertion macros used by the allocator controller.
`ifndef CONTIGUOUS_BLOCK_ALLOCATOR_UNIT_ASSERT_SVH
`define CONTIGUOUS_BLOCK_ALLOCATOR_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CBAU_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("allocator assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define CBAU_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("allocator assertion failed");

`endif

// ----- rtl/cbau_pkg.sv -----
// Types and codes of the contiguous block allocator.
package cbau_pkg;

   typedef enum logic [1:0] {
      REQ_ALLOC   = 2'd0,
      REQ_RELEASE = 2'd1,
      REQ_COMPACT = 2'd2,
      REQ_STATUS  = 2'd3
   } req_code_type;

   localparam logic [1:0] FIT_FIRST = 2'd0;
   localparam logic [1:0] FIT_BEST  = 2'd1;
   localparam logic [1:0] FIT_WORST = 2'd2;
   localparam logic [1:0] FIT_BAD   = 2'd3;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_NO_FIT   = 3'd1;
   localparam logic [2:0] ST_NO_OWNER = 3'd2;
   localparam logic [2:0] ST_BAD_REQ  = 3'd3;
   localparam logic [2:0] ST_FULL     = 3'd4;

   localparam logic [31:0] MEM_SIZE_RESET = 32'd65536;

   typedef struct packed {
      logic [15:0] owner;
      logic [31:0] size;
   } entry_type;

   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } mem_ctl_type;

endpackage

// ----- rtl/cbau_req_if.sv -----
// Request channel of the allocator.
interface cbau_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic [15:0] owner_id;
   logic [31:0] request_size;
   logic [1:0]  fit_policy;

   modport source (output valid, req_type, owner_id, request_size, fit_policy, input ready);
   modport sink (input valid, req_type, owner_id, request_size, fit_policy, output ready);
endinterface

// ----- rtl/cbau_rsp_if.sv -----
// Result channel of the allocator.
interface cbau_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [31:0] block_start;
   logic [31:0] block_size;
   logic [15:0] block_owner;
   logic        block_used;
   logic        last;

   modport source (output valid, status, block_start, block_size, block_owner, block_used,
                   last, input ready);
   modport sink (input valid, status, block_start, block_size, block_owner, block_used,
                 last, output ready);
endinterface

// ----- rtl/cbau_table_mem.sv -----
// Block table memory: one write port, one registered read port.
module cbau_table_mem
   import cbau_pkg::*;
#(
   parameter int MAX_BLOCKS = 32,
   parameter int IW = $clog2(MAX_BLOCKS)
) (
   input  logic          clock,
   input  mem_ctl_type   mem_ctl,
   input  logic [IW-1:0] wr_addr,
   input  entry_type     wr_data,
   input  logic [IW-1:0] rd_addr,
   output entry_type     rd_data
);
   entry_type mem [MAX_BLOCKS];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_ctl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (mem_ctl.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ----- rtl/cbau_ctrl.sv -----
// Request sequencer: scans, splits, merges, compacts and lists the block table.
`include "contiguous_block_allocator_unit_assert.svh"
module cbau_ctrl
   import cbau_pkg::*;
#(
   parameter int MAX_BLOCKS = 32,
   parameter int IW = $clog2(MAX_BLOCKS)
) (
   input  logic          clock,
   input  logic          reset,
   cbau_req_if.sink      req_ch,
   cbau_rsp_if.source    rsp_ch,
   input  logic          csr_we,
   input  logic [31:0]   csr_wdata,
   output mem_ctl_type   mem_ctl,
   output logic [IW-1:0] wr_addr,
   output entry_type     wr_data,
   output logic [IW-1:0] rd_addr,
   input  entry_type     rd_data
);
   localparam int CW = $clog2(MAX_BLOCKS + 1);
   localparam int FW = 32 + CW;
   localparam logic [CW-1:0] MAX_CNT = CW'(MAX_BLOCKS);

   typedef enum logic [10:0] {
      S_INIT   = 11'b00000000001,
      S_IDLE   = 11'b00000000010,
      S_SCAN   = 11'b00000000100,
      S_DECIDE = 11'b00000001000,
      S_SHUP   = 11'b00000010000,
      S_FIN1   = 11'b00000100000,
      S_FIN2   = 11'b00001000000,
      S_SHDN   = 11'b00010000000,
      S_RESP   = 11'b00100000000,
      S_STRD   = 11'b01000000000,
      S_STOUT  = 11'b10000000000
   } state_type;

   state_type     state_ff, state_in;
   logic [31:0]   mem_size_ff, mem_size_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   req_code_type  op_ff, op_in;
   logic [15:0]   own_ff, own_in;
   logic [31:0]   rsz_ff, rsz_in;
   logic [1:0]    pol_ff, pol_in;
   logic [CW-1:0] ridx_ff, ridx_in;
   logic          rvld_ff, rvld_in;
   logic [IW-1:0] eidx_ff, eidx_in;
   logic [31:0]   acc_ff, acc_in;
   logic          found_ff, found_in;
   logic [IW-1:0] pos_ff, pos_in;
   logic [31:0]   psize_ff, psize_in;
   logic [31:0]   pstart_ff, pstart_in;
   logic          lfree_ff, lfree_in;
   logic [31:0]   lsize_ff, lsize_in;
   logic          rfree_ff, rfree_in;
   logic [31:0]   rsize_ff, rsize_in;
   logic          grab_ff, grab_in;
   logic [15:0]   prev_own_ff, prev_own_in;
   logic [31:0]   prev_size_ff, prev_size_in;
   logic [CW-1:0] n_ff, n_in;
   logic [FW-1:0] fsum_ff, fsum_in;
   logic [1:0]    k_ff, k_in;
   logic          split_ff, split_in;
   logic [2:0]    ost_ff, ost_in;
   logic [31:0]   obs_ff, obs_in;
   logic [31:0]   obz_ff, obz_in;
   logic [15:0]   obo_ff, obo_in;
   logic          obu_ff, obu_in;
   logic          rv_ff, rv_in;
   logic [2:0]    rst_ff, rst_in;
   logic [31:0]   rbs_ff, rbs_in;
   logic [31:0]   rbz_ff, rbz_in;
   logic [15:0]   rbo_ff, rbo_in;
   logic          rbu_ff, rbu_in;
   logic          rlast_ff, rlast_in;

   logic          slot_free;
   logic          take;
   logic [IW-1:0] tgt;
   logic [31:0]   merged;
   logic [1:0]    kk;

   assign slot_free = !rv_ff || rsp_ch.ready;
   assign req_ch.ready = (state_ff == S_IDLE) && !csr_we;

   assign rsp_ch.valid = rv_ff;
   assign rsp_ch.status = rst_ff;
   assign rsp_ch.block_start = rbs_ff;
   assign rsp_ch.block_size = rbz_ff;
   assign rsp_ch.block_owner = rbo_ff;
   assign rsp_ch.block_used = rbu_ff;
   assign rsp_ch.last = rlast_ff;

   // Release merge: target entry and number of entries removed behind it.
   assign kk = {1'b0, lfree_ff} + {1'b0, rfree_ff};
   assign tgt = lfree_ff ? IW'(pos_ff - 1'b1) : pos_ff;
   assign merged = (lfree_ff ? lsize_ff : 32'd0) + psize_ff + (rfree_ff ? rsize_ff : 32'd0);

   always_comb begin
      state_in = state_ff;     mem_size_in = mem_size_ff; cnt_in = cnt_ff;
      op_in = op_ff;           own_in = own_ff;           rsz_in = rsz_ff;
      pol_in = pol_ff;         ridx_in = ridx_ff;         rvld_in = 1'b0;
      eidx_in = eidx_ff;       acc_in = acc_ff;           found_in = found_ff;
      pos_in = pos_ff;         psize_in = psize_ff;       pstart_in = pstart_ff;
      lfree_in = lfree_ff;     lsize_in = lsize_ff;       rfree_in = rfree_ff;
      rsize_in = rsize_ff;     grab_in = grab_ff;         prev_own_in = prev_own_ff;
      prev_size_in = prev_size_ff; n_in = n_ff;           fsum_in = fsum_ff;
      k_in = k_ff;             split_in = split_ff;
      ost_in = ost_ff; obs_in = obs_ff; obz_in = obz_ff; obo_in = obo_ff; obu_in = obu_ff;
      rv_in = rv_ff && !rsp_ch.ready;
      rst_in = rst_ff; rbs_in = rbs_ff; rbz_in = rbz_ff; rbo_in = rbo_ff; rbu_in = rbu_ff;
      rlast_in = rlast_ff;
      mem_ctl = '0;
      wr_addr = '0;
      wr_data = '0;
      rd_addr = '0;
      take = 1'b0;

      case (state_ff)
         S_INIT: begin
            mem_ctl.wr_en = 1'b1;
            wr_data.size = csr_we ? csr_wdata : mem_size_ff;
            if (csr_we) begin
               mem_size_in = csr_wdata;
            end
            cnt_in = CW'(1);
            state_in = S_IDLE;
         end
         S_IDLE: begin
            if (csr_we) begin
               mem_size_in = csr_wdata;
               cnt_in = CW'(1);
               mem_ctl.wr_en = 1'b1;
               wr_data.size = csr_wdata;
            end else if (req_ch.valid) begin
               op_in = req_code_type'(req_ch.req_type);
               own_in = req_ch.owner_id;
               rsz_in = req_ch.request_size;
               pol_in = req_ch.fit_policy;
               ridx_in = '0;
               acc_in = '0;
               found_in = 1'b0;
               lfree_in = 1'b0;
               rfree_in = 1'b0;
               grab_in = 1'b0;
               n_in = '0;
               fsum_in = '0;
               ost_in = ST_BAD_REQ; obs_in = '0; obz_in = '0; obo_in = '0; obu_in = 1'b0;
               case (req_code_type'(req_ch.req_type))
                  REQ_ALLOC: begin
                     if (req_ch.request_size == 32'd0 || req_ch.owner_id == 16'd0 ||
                         req_ch.fit_policy == FIT_BAD) begin
                        state_in = S_RESP;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  REQ_RELEASE: begin
                     state_in = (req_ch.owner_id == 16'd0) ? S_RESP : S_SCAN;
                  end
                  REQ_COMPACT: state_in = S_SCAN;
                  default: state_in = S_STRD;
               endcase
            end
         end
         S_SCAN: begin
            if (ridx_ff < cnt_ff) begin
               mem_ctl.rd_en = 1'b1;
               rd_addr = ridx_ff[IW-1:0];
               eidx_in = ridx_ff[IW-1:0];
               ridx_in = ridx_ff + 1'b1;
               rvld_in = 1'b1;
            end
            if (rvld_ff) begin
               acc_in = acc_ff + rd_data.size;
               prev_own_in = rd_data.owner;
               prev_size_in = rd_data.size;
               case (op_ff)
                  REQ_ALLOC: begin
                     take = rd_data.owner == 16'd0 && rd_data.size >= rsz_ff &&
                            (!found_ff || (pol_ff == FIT_BEST && rd_data.size < psize_ff) ||
                             (pol_ff == FIT_WORST && rd_data.size > psize_ff));
                     if (take) begin
                        found_in = 1'b1;
                        pos_in = eidx_ff;
                        psize_in = rd_data.size;
                        pstart_in = acc_ff;
                     end
                  end
                  REQ_RELEASE: begin
                     if (!found_ff && rd_data.owner == own_ff) begin
                        found_in = 1'b1;
                        pos_in = eidx_ff;
                        psize_in = rd_data.size;
                        pstart_in = acc_ff;
                        lfree_in = (eidx_ff != '0) && prev_own_ff == 16'd0;
                        lsize_in = prev_size_ff;
                        grab_in = 1'b1;
                     end else if (grab_ff) begin
                        rfree_in = rd_data.owner == 16'd0;
                        rsize_in = rd_data.size;
                        grab_in = 1'b0;
                     end
                  end
                  default: begin
                     // Used blocks slide down to the next packed slot.
                     if (rd_data.owner != 16'd0) begin
                        mem_ctl.wr_en = 1'b1;
                        wr_addr = n_ff[IW-1:0];
                        wr_data = rd_data;
                        n_in = n_ff + 1'b1;
                     end else begin
                        fsum_in = fsum_ff + FW'(rd_data.size);
                     end
                  end
               endcase
            end else if (ridx_ff >= cnt_ff) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            case (op_ff)
               REQ_ALLOC: begin
                  if (!found_ff) begin
                     ost_in = ST_NO_FIT;
                     state_in = S_RESP;
                  end else if (psize_ff != rsz_ff) begin
                     if (cnt_ff == MAX_CNT) begin
                        ost_in = ST_FULL;
                        state_in = S_RESP;
                     end else begin
                        split_in = 1'b1;
                        ridx_in = cnt_ff;
                        state_in = S_SHUP;
                     end
                  end else begin
                     split_in = 1'b0;
                     state_in = S_FIN2;
                  end
               end
               REQ_RELEASE: begin
                  if (!found_ff) begin
                     ost_in = ST_NO_OWNER;
                     state_in = S_RESP;
                  end else begin
                     ost_in = ST_OK;
                     obs_in = pstart_ff;
                     obz_in = psize_ff;
                     mem_ctl.wr_en = 1'b1;
                     wr_addr = tgt;
                     wr_data.size = merged;
                     k_in = kk;
                     ridx_in = CW'(tgt) + 1'b1 + CW'(kk);
                     state_in = (kk == 2'd0) ? S_RESP : S_SHDN;
                  end
               end
               default: begin
                  ost_in = ST_OK;
                  if (fsum_ff != '0 || n_ff == '0) begin
                     mem_ctl.wr_en = 1'b1;
                     wr_addr = n_ff[IW-1:0];
                     wr_data.size = fsum_ff[31:0];
                     cnt_in = n_ff + 1'b1;
                  end else begin
                     cnt_in = n_ff;
                  end
                  state_in = S_RESP;
               end
            endcase
         end
         S_SHUP: begin
            // Entries above the split move up by one, highest first.
            if (ridx_ff > CW'(pos_ff) + 1'b1) begin
               mem_ctl.rd_en = 1'b1;
               rd_addr = IW'(ridx_ff - 1'b1);
               eidx_in = IW'(ridx_ff - 1'b1);
               ridx_in = ridx_ff - 1'b1;
               rvld_in = 1'b1;
            end
            if (rvld_ff) begin
               mem_ctl.wr_en = 1'b1;
               wr_addr = IW'(eidx_ff + 1'b1);
               wr_data = rd_data;
            end else if (!(ridx_ff > CW'(pos_ff) + 1'b1)) begin
               state_in = S_FIN1;
            end
         end
         S_FIN1: begin
            mem_ctl.wr_en = 1'b1;
            wr_addr = IW'(pos_ff + 1'b1);
            wr_data.size = psize_ff - rsz_ff;
            state_in = S_FIN2;
         end
         S_FIN2: begin
            mem_ctl.wr_en = 1'b1;
            wr_addr = pos_ff;
            wr_data.owner = own_ff;
            wr_data.size = rsz_ff;
            if (split_ff) begin
               cnt_in = cnt_ff + 1'b1;
            end
            ost_in = ST_OK; obs_in = pstart_ff; obz_in = rsz_ff; obo_in = own_ff; obu_in = 1'b1;
            state_in = S_RESP;
         end
         S_SHDN: begin
            // Entries behind the merged block move down over the removed ones.
            if (ridx_ff < cnt_ff) begin
               mem_ctl.rd_en = 1'b1;
               rd_addr = ridx_ff[IW-1:0];
               eidx_in = ridx_ff[IW-1:0];
               ridx_in = ridx_ff + 1'b1;
               rvld_in = 1'b1;
            end
            if (rvld_ff) begin
               mem_ctl.wr_en = 1'b1;
               wr_addr = IW'(eidx_ff - k_ff);
               wr_data = rd_data;
            end else if (ridx_ff >= cnt_ff) begin
               cnt_in = cnt_ff - CW'(k_ff);
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (slot_free) begin
               rv_in = 1'b1;
               rst_in = ost_ff; rbs_in = obs_ff; rbz_in = obz_ff; rbo_in = obo_ff;
               rbu_in = obu_ff; rlast_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_STRD: begin
            mem_ctl.rd_en = 1'b1;
            rd_addr = ridx_ff[IW-1:0];
            ridx_in = ridx_ff + 1'b1;
            state_in = S_STOUT;
         end
         S_STOUT: begin
            if (slot_free) begin
               rv_in = 1'b1;
               rst_in = ST_OK;
               rbs_in = acc_ff;
               rbz_in = rd_data.size;
               rbo_in = rd_data.owner;
               rbu_in = rd_data.owner != 16'd0;
               rlast_in = ridx_ff == cnt_ff;
               acc_in = acc_ff + rd_data.size;
               state_in = (ridx_ff == cnt_ff) ? S_IDLE : S_STRD;
            end
         end
         default: state_in = S_INIT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         mem_size_ff <= MEM_SIZE_RESET;
         cnt_ff <= CW'(1);
         rvld_ff <= 1'b0;
         rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         mem_size_ff <= mem_size_in;
         cnt_ff <= cnt_in;
         rvld_ff <= rvld_in;
         rv_ff <= rv_in;
      end
      op_ff <= op_in;         own_ff <= own_in;       rsz_ff <= rsz_in;
      pol_ff <= pol_in;       ridx_ff <= ridx_in;     eidx_ff <= eidx_in;
      acc_ff <= acc_in;       found_ff <= found_in;   pos_ff <= pos_in;
      psize_ff <= psize_in;   pstart_ff <= pstart_in; lfree_ff <= lfree_in;
      lsize_ff <= lsize_in;   rfree_ff <= rfree_in;   rsize_ff <= rsize_in;
      grab_ff <= grab_in;     prev_own_ff <= prev_own_in; prev_size_ff <= prev_size_in;
      n_ff <= n_in;           fsum_ff <= fsum_in;     k_ff <= k_in;
      split_ff <= split_in;
      ost_ff <= ost_in; obs_ff <= obs_in; obz_ff <= obz_in; obo_ff <= obo_in; obu_ff <= obu_in;
      rst_ff <= rst_in; rbs_ff <= rbs_in; rbz_ff <= rbz_in; rbo_ff <= rbo_in; rbu_ff <= rbu_in;
      rlast_ff <= rlast_in;
   end

   `CBAU_ASSERT_SAME(a_cnt_range, clock, reset, 1'b1, cnt_ff != '0 && cnt_ff <= MAX_CNT)
   `CBAU_ASSERT_SAME(a_accept_quiet, clock, reset, req_ch.valid && req_ch.ready, !rvld_ff)
   `CBAU_ASSERT_NEXT(a_resp_loads, clock, reset, state_ff == S_RESP && slot_free, rv_ff && rlast_ff)
   `CBAU_ASSERT_SAME(a_no_split_full, clock, reset, state_ff == S_FIN1, cnt_ff < MAX_CNT)
endmodule

// ----- rtl/contiguous_block_allocator_unit.sv -----
// Contiguous block allocator: first, best and worst fit over a block table.
// Requests arrive on req_ch (valid/ready); a transfer takes one request: allocate,
// release, compact or status. Results leave on rsp_ch; each request yields one
// result with last set, except status, which lists every table entry in address
// order and sets last on the final one. csr_we with csr_wdata writes the managed
// memory size and resets the table to one free block; write only while idle.
// Allocate, release and compact scan the table at one entry per cycle from the
// single read port, then decide; a split moves the entries above the found block
// up and writes the remainder and the allocated block, a merge moves the entries
// behind the merged block down. Status reads each entry and then issues it as a
// result; a stalled receiver holds the listing. One request is in work at a time.
// After reset the init state writes the initial free block of 65536 units, then the
// block takes requests. The result register lets the next request start while a
// result waits; a stalled receiver holds the block at its next result.
module contiguous_block_allocator_unit
   import cbau_pkg::*;
#(
   parameter int MAX_BLOCKS = 32
) (
   input  logic        clock,
   input  logic        reset,
   cbau_req_if.sink    req_ch,
   cbau_rsp_if.source  rsp_ch,
   input  logic        csr_we,
   input  logic [31:0] csr_wdata
);
   localparam int IW = $clog2(MAX_BLOCKS);

   mem_ctl_type   mem_ctl;
   logic [IW-1:0] wr_addr;
   logic [IW-1:0] rd_addr;
   entry_type     wr_data;
   entry_type     rd_data;

   cbau_ctrl #(.MAX_BLOCKS(MAX_BLOCKS), .IW(IW)) u_ctrl (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
      .csr_we(csr_we), .csr_wdata(csr_wdata), .mem_ctl(mem_ctl),
      .wr_addr(wr_addr), .wr_data(wr_data), .rd_addr(rd_addr), .rd_data(rd_data)
   );

   cbau_table_mem #(.MAX_BLOCKS(MAX_BLOCKS), .IW(IW)) u_mem (
      .clock(clock), .mem_ctl(mem_ctl), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );
endmodule
